// ===== sv/brc_pkg.sv =====
package brc_pkg;

   localparam int CamEntriesDefault = 8;
   localparam int NumPortsDefault = 5;
   localparam int PayloadBitsDefault = 32;

   localparam int AddrBits = 16;
   localparam int IdBits = 6;
   localparam int KeyBits = AddrBits + IdBits;
   localparam int MaskBits = 5;
   localparam int StatusBits = 3;
   localparam int PortBits = 3;
   localparam int ServiceBits = 2;

   typedef enum logic [ServiceBits-1:0] {
      SVC_ALL     = 2'd0,
      SVC_TARGET  = 2'd1,
      SVC_CLEAR   = 2'd2,
      SVC_INVALID = 2'd3
   } service_type;

   typedef enum logic [StatusBits-1:0] {
      ST_IGNORED  = 3'd0,
      ST_STORED   = 3'd1,
      ST_REFUSED  = 3'd2,
      ST_CLEARED  = 3'd3,
      ST_TICK     = 3'd4,
      ST_LAUNCHED = 3'd5
   } status_type;

   typedef enum logic [0:0] {
      CMD_PACKET = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_ROUTER_ADDRESS = 1'b0,
      CSR_CLEAR_INTERVAL = 1'b1
   } csr_index_type;

   localparam logic [AddrBits-1:0] ClearIntervalReset = 16'd100;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_STORE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_LAUNCH = 2'd3
   } action_type;

endpackage

// ===== sv/brc_front.sv =====
module brc_front
   import brc_pkg::*;
#(
   parameter int CAM_ENTRIES = CamEntriesDefault,
   parameter int NUM_PORTS = NumPortsDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault,
   localparam int IdxBits = (CAM_ENTRIES > 1) ? $clog2(CAM_ENTRIES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [PortBits-1:0]     req_in_port,
   input  logic [AddrBits-1:0]     req_src_addr,
   input  logic [AddrBits-1:0]     req_tgt_addr,
   input  logic [IdBits-1:0]       req_msg_id,
   input  logic [ServiceBits-1:0]  req_service,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   input  logic [AddrBits-1:0]     node_addr,
   input  logic [AddrBits-1:0]     tick_limit,
   output logic                    job_valid,
   input  logic                    job_ready,
   output action_type              job_action,
   output status_type              job_status,
   output logic [MaskBits-1:0]     job_mask,
   output logic [IdxBits-1:0]      job_index,
   output logic [ServiceBits-1:0]  job_service,
   output logic [AddrBits-1:0]     job_src,
   output logic [AddrBits-1:0]     job_tgt,
   output logic [IdBits-1:0]       job_id,
   output logic [PAYLOAD_BITS-1:0] job_payload
);

   localparam int MeshPorts = NUM_PORTS - 1;

   logic [CAM_ENTRIES-1:0] valid_ff, valid_in;
   logic [KeyBits-1:0]     key_ff [CAM_ENTRIES];
   logic [PortBits-1:0]    origin_ff [CAM_ENTRIES];
   logic                   armed_ff, armed_in;
   logic [AddrBits-1:0]    elapsed_ff, elapsed_in;
   logic [IdxBits-1:0]     lentry_ff, lentry_in;

   logic                   pend_ff, pend_in;
   logic                   cmd_ff;
   logic [PortBits-1:0]    port_ff;
   logic [AddrBits-1:0]    src_ff, tgt_ff;
   logic [IdBits-1:0]      id_ff;
   logic [ServiceBits-1:0] svc_ff;
   logic [PAYLOAD_BITS-1:0] pay_ff;
   logic [CAM_ENTRIES-1:0] hitv_ff;

   logic                   out_ff, out_in;
   action_type             act_ff, act_in;
   status_type             st_ff, st_in;
   logic [MaskBits-1:0]    mask_ff, mask_in;
   logic [IdxBits-1:0]     idx_ff, idx_in;
   logic [ServiceBits-1:0] osvc_ff, osvc_in;

   logic                   hit_any, free_any, wr_en;
   logic [IdxBits-1:0]     hit_idx, vacant_idx;
   logic [AddrBits-1:0]    elapsed_inc;

   function automatic logic [MaskBits-1:0] mesh_except(input logic [PortBits-1:0] origin);
      logic [MaskBits-1:0] m;
      m = '0;
      for (int p = 0; p < MeshPorts; p++) begin
         if (p < MaskBits) m[p] = (origin != PortBits'(p));
      end
      return m;
   endfunction

   assign req_ready = !pend_ff && !out_ff;

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      free_any = 1'b0;
      vacant_idx = '0;
      for (int i = CAM_ENTRIES - 1; i >= 0; i--) begin
         if (hitv_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = IdxBits'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            vacant_idx = IdxBits'(i);
         end
      end
   end

   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + AddrBits'(1);

   always_comb begin
      valid_in = valid_ff;
      armed_in = armed_ff;
      elapsed_in = elapsed_ff;
      lentry_in = lentry_ff;
      pend_in = pend_ff;
      out_in = out_ff && !job_ready;
      act_in = act_ff;
      st_in = st_ff;
      mask_in = mask_ff;
      idx_in = idx_ff;
      osvc_in = osvc_ff;
      wr_en = 1'b0;
      if (req_valid && req_ready) pend_in = 1'b1;
      if (pend_ff) begin
         pend_in = 1'b0;
         out_in = 1'b1;
         act_in = ACT_NONE;
         mask_in = '0;
         idx_in = '0;
         osvc_in = '0;
         if (cmd_ff == CMD_TICK) begin
            st_in = ST_TICK;
            if (armed_ff) begin
               elapsed_in = elapsed_inc;
               if (elapsed_inc >= tick_limit) begin
                  armed_in = 1'b0;
                  if (valid_ff[lentry_ff]) begin
                     valid_in[lentry_ff] = 1'b0;
                     st_in = ST_LAUNCHED;
                     act_in = ACT_LAUNCH;
                     mask_in = mesh_except(origin_ff[lentry_ff]);
                     idx_in = lentry_ff;
                     osvc_in = SVC_CLEAR;
                  end
               end
            end
         end else if (32'(port_ff) >= NUM_PORTS) begin
            st_in = ST_IGNORED;
         end else if (!hit_any && (svc_ff == SVC_ALL || svc_ff == SVC_TARGET)) begin
            if (!free_any) begin
               st_in = ST_REFUSED;
            end else begin
               wr_en = 1'b1;
               valid_in[vacant_idx] = 1'b1;
               st_in = ST_STORED;
               act_in = ACT_STORE;
               idx_in = vacant_idx;
               osvc_in = svc_ff;
               if (32'(port_ff) == NUM_PORTS - 1) begin
                  armed_in = 1'b1;
                  elapsed_in = '0;
                  lentry_in = vacant_idx;
               end
               if (svc_ff == SVC_ALL) begin
                  mask_in = mesh_except(port_ff);
                  if (src_ff != node_addr) mask_in[MeshPorts] = 1'b1;
               end else if (tgt_ff != node_addr) begin
                  mask_in = mesh_except(port_ff);
               end else begin
                  mask_in[MeshPorts] = 1'b1;
               end
            end
         end else if (hit_any && svc_ff == SVC_CLEAR) begin
            valid_in[hit_idx] = 1'b0;
            if (armed_ff && lentry_ff == hit_idx) armed_in = 1'b0;
            st_in = ST_CLEARED;
            act_in = ACT_CLEAR;
            mask_in = mesh_except(origin_ff[hit_idx]);
            idx_in = hit_idx;
            osvc_in = SVC_CLEAR;
         end else begin
            st_in = ST_IGNORED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         armed_ff <= 1'b0;
         elapsed_ff <= '0;
         lentry_ff <= '0;
         pend_ff <= 1'b0;
         out_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         armed_ff <= armed_in;
         elapsed_ff <= elapsed_in;
         lentry_ff <= lentry_in;
         pend_ff <= pend_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
         port_ff <= req_in_port;
         src_ff <= req_src_addr;
         tgt_ff <= req_tgt_addr;
         id_ff <= req_msg_id;
         svc_ff <= req_service;
         pay_ff <= req_payload;
         for (int i = 0; i < CAM_ENTRIES; i++) begin
            hitv_ff[i] <= valid_ff[i] && (key_ff[i] == {req_src_addr, req_msg_id});
         end
      end
      if (wr_en) begin
         key_ff[vacant_idx] <= {src_ff, id_ff};
         origin_ff[vacant_idx] <= port_ff;
      end
      if (pend_ff) begin
         act_ff <= act_in;
         st_ff <= st_in;
         mask_ff <= mask_in;
         idx_ff <= idx_in;
         osvc_ff <= osvc_in;
         job_src <= src_ff;
         job_tgt <= tgt_ff;
         job_id <= id_ff;
         job_payload <= pay_ff;
      end
   end

   assign job_valid = out_ff;
   assign job_action = act_ff;
   assign job_status = st_ff;
   assign job_mask = mask_ff;
   assign job_index = idx_ff;
   assign job_service = osvc_ff;

endmodule

// ===== sv/brc_back.sv =====
module brc_back
   import brc_pkg::*;
#(
   parameter int CAM_ENTRIES = CamEntriesDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault,
   localparam int IdxBits = (CAM_ENTRIES > 1) ? $clog2(CAM_ENTRIES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   output logic                    job_ready,
   input  action_type              job_action,
   input  status_type              job_status,
   input  logic [MaskBits-1:0]     job_mask,
   input  logic [IdxBits-1:0]      job_index,
   input  logic [ServiceBits-1:0]  job_service,
   input  logic [AddrBits-1:0]     job_src,
   input  logic [AddrBits-1:0]     job_tgt,
   input  logic [IdBits-1:0]       job_id,
   input  logic [PAYLOAD_BITS-1:0] job_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [StatusBits-1:0]   rsp_status,
   output logic [MaskBits-1:0]     rsp_fwd_mask,
   output logic [AddrBits-1:0]     rsp_out_source,
   output logic [AddrBits-1:0]     rsp_out_target,
   output logic [IdBits-1:0]       rsp_out_id,
   output logic [ServiceBits-1:0]  rsp_out_service,
   output logic [PAYLOAD_BITS-1:0] rsp_out_payload
);

   localparam int InfoBits = 2 * AddrBits + IdBits + PAYLOAD_BITS;

   logic [InfoBits-1:0] mem_ff [CAM_ENTRIES];
   logic [InfoBits-1:0] rd_ff;
   logic                stage_ff, stage_in;
   action_type          act_ff;
   status_type          st_ff;
   logic [MaskBits-1:0] mask_ff;
   logic [ServiceBits-1:0] svc_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                load;

   assign job_ready = !stage_ff;
   assign load = stage_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      stage_in = stage_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load) begin
         stage_in = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (job_valid && job_ready) stage_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         act_ff <= job_action;
         st_ff <= job_status;
         mask_ff <= job_mask;
         svc_ff <= job_service;
         if (job_action == ACT_STORE) begin
            mem_ff[job_index] <= {job_src, job_tgt, job_id, job_payload};
            rd_ff <= {job_src, job_tgt, job_id, job_payload};
         end else begin
            rd_ff <= mem_ff[job_index];
         end
      end
      if (load) begin
         rsp_status <= st_ff;
         rsp_fwd_mask <= mask_ff;
         rsp_out_service <= svc_ff;
         if (act_ff == ACT_NONE) begin
            {rsp_out_source, rsp_out_target, rsp_out_id, rsp_out_payload} <= '0;
         end else begin
            {rsp_out_source, rsp_out_target, rsp_out_id, rsp_out_payload} <= rd_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/broadcast_router_cam.sv =====
// Broadcast router with duplicate-suppressing CAM.
// req_ channel: one word per packet arrival (req_cmd 0) or clock tick
// (req_cmd 1). rsp_ channel: exactly one result word per request word,
// in order. csr_ channel: index 0 writes the node address, 1 writes
// the clear tick limit; write only while the block is idle.
// A front stage registers the CAM key compare on acceptance, then resolves
// hit, free entry, timer and forward mask in the next cycle and queues a
// job. A back stage reads or writes the entry store and registers the
// result. The front takes no new word until the current one has been through
// the compare, the resolve and the job handoff to the back stage.
// Reset empties the CAM, disarms the timer, sets the node address to 0 and
// the clear tick limit to 100. When rsp_ready is low, the result holds, the
// back stage and job register fill, and req_ready drops until space frees.
module broadcast_router_cam
   import brc_pkg::*;
#(
   parameter int CAM_ENTRIES = CamEntriesDefault,
   parameter int NUM_PORTS = NumPortsDefault,
   parameter int PAYLOAD_BITS = PayloadBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_cmd,
   input  logic [PortBits-1:0]     req_in_port,
   input  logic [AddrBits-1:0]     req_src_addr,
   input  logic [AddrBits-1:0]     req_tgt_addr,
   input  logic [IdBits-1:0]       req_msg_id,
   input  logic [ServiceBits-1:0]  req_service,
   input  logic [PAYLOAD_BITS-1:0] req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [StatusBits-1:0]   rsp_status,
   output logic [MaskBits-1:0]     rsp_fwd_mask,
   output logic [AddrBits-1:0]     rsp_out_source,
   output logic [AddrBits-1:0]     rsp_out_target,
   output logic [IdBits-1:0]       rsp_out_id,
   output logic [ServiceBits-1:0]  rsp_out_service,
   output logic [PAYLOAD_BITS-1:0] rsp_out_payload,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic                    csr_index,
   input  logic [AddrBits-1:0]     csr_data
);

   localparam int IdxBits = (CAM_ENTRIES > 1) ? $clog2(CAM_ENTRIES) : 1;

   logic [AddrBits-1:0] addr_ff, interval_ff;
   logic                job_valid, job_ready;
   action_type          job_action;
   status_type          job_status;
   logic [MaskBits-1:0] job_mask;
   logic [IdxBits-1:0]  job_index;
   logic [ServiceBits-1:0] job_service;
   logic [AddrBits-1:0] job_src, job_tgt;
   logic [IdBits-1:0]   job_id;
   logic [PAYLOAD_BITS-1:0] job_payload;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         interval_ff <= ClearIntervalReset;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROUTER_ADDRESS: addr_ff <= csr_data;
            CSR_CLEAR_INTERVAL: interval_ff <= csr_data;
            default: addr_ff <= addr_ff;
         endcase
      end
   end

   brc_front #(
      .CAM_ENTRIES(CAM_ENTRIES),
      .NUM_PORTS(NUM_PORTS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_cmd, .req_in_port,
      .req_src_addr, .req_tgt_addr, .req_msg_id, .req_service, .req_payload,
      .node_addr(addr_ff), .tick_limit(interval_ff),
      .job_valid, .job_ready, .job_action, .job_status, .job_mask, .job_index,
      .job_service, .job_src, .job_tgt, .job_id, .job_payload
   );

   brc_back #(
      .CAM_ENTRIES(CAM_ENTRIES),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) u_back (
      .clock, .reset, .job_valid, .job_ready, .job_action, .job_status,
      .job_mask, .job_index, .job_service, .job_src, .job_tgt, .job_id,
      .job_payload, .rsp_valid, .rsp_ready, .rsp_status, .rsp_fwd_mask,
      .rsp_out_source, .rsp_out_target, .rsp_out_id, .rsp_out_service,
      .rsp_out_payload
   );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import brc_pkg::*;

   localparam int Entries = 8;
   localparam int MeshPorts = 4;
   localparam int LocalPort = 4;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic        cmd;
      logic [2:0]  in_port;
      logic [15:0] src_addr;
      logic [15:0] tgt_addr;
      logic [5:0]  msg_id;
      logic [1:0]  service;
      logic [31:0] payload;
   } packet_word;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  fwd_mask;
      logic [15:0] out_source;
      logic [15:0] out_target;
      logic [5:0]  out_id;
      logic [1:0]  out_service;
      logic [31:0] out_payload;
   } route_word;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = 1'b0;
   logic [2:0] req_in_port = '0;
   logic [15:0] req_src_addr = '0;
   logic [15:0] req_tgt_addr = '0;
   logic [5:0] req_msg_id = '0;
   logic [1:0] req_service = '0;
   logic [31:0] req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_fwd_mask;
   logic [15:0] rsp_out_source;
   logic [15:0] rsp_out_target;
   logic [5:0] rsp_out_id;
   logic [1:0] rsp_out_service;
   logic [31:0] rsp_out_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [15:0] csr_data = '0;

   broadcast_router_cam dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // router model state
   logic [15:0] own_addr;
   logic [15:0] interval;
   logic        cam_valid [Entries];
   logic [15:0] cam_src [Entries];
   logic [5:0]  cam_id [Entries];
   logic [2:0]  cam_origin [Entries];
   logic [15:0] cam_tgt [Entries];
   logic [31:0] cam_payload [Entries];
   logic        timer_armed;
   logic [15:0] timer_count;
   int          timer_entry;

   packet_word pending_words[$];
   route_word  expected_routes[$];
   int  errors = 0;
   int  cycles = 0;
   int  sent = 0;
   int  received = 0;
   int  send_wait = 0;
   int  recv_wait = 0;
   bit  calm = 1'b0;
   bit  req_taken = 1'b0;

   function automatic logic [4:0] mesh_except(input logic [2:0] origin);
      logic [4:0] m;
      m = 5'b01111;
      if (origin < MeshPorts) m[origin] = 1'b0;
      return m;
   endfunction

   function automatic route_word entry_route(input logic [2:0] st, input logic [4:0] mask,
                                             input int e, input logic [1:0] svc);
      route_word r;
      r.status = st;
      r.fwd_mask = mask;
      r.out_source = cam_src[e];
      r.out_target = cam_tgt[e];
      r.out_id = cam_id[e];
      r.out_service = svc;
      r.out_payload = cam_payload[e];
      return r;
   endfunction

   function automatic route_word route_packet(input packet_word p);
      route_word r;
      int hit, free_slot;
      logic [4:0] mask;
      r = '0;
      hit = -1;
      free_slot = -1;
      if (p.cmd == CMD_TICK) begin
         r.status = ST_TICK;
         if (!timer_armed) return r;
         if (timer_count != 16'hFFFF) timer_count++;
         if (timer_count >= interval) begin
            timer_armed = 1'b0;
            if (cam_valid[timer_entry]) begin
               cam_valid[timer_entry] = 1'b0;
               return entry_route(ST_LAUNCHED, mesh_except(cam_origin[timer_entry]),
                                  timer_entry, SVC_CLEAR);
            end
         end
         return r;
      end
      r.status = ST_IGNORED;
      if (p.in_port > LocalPort) return r;
      for (int i = 0; i < Entries; i++) begin
         if (cam_valid[i]) begin
            if (hit < 0 && cam_src[i] == p.src_addr && cam_id[i] == p.msg_id) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit < 0 && (p.service == SVC_ALL || p.service == SVC_TARGET)) begin
         if (free_slot < 0) begin
            r.status = ST_REFUSED;
            return r;
         end
         cam_valid[free_slot] = 1'b1;
         cam_src[free_slot] = p.src_addr;
         cam_id[free_slot] = p.msg_id;
         cam_origin[free_slot] = p.in_port;
         cam_tgt[free_slot] = p.tgt_addr;
         cam_payload[free_slot] = p.payload;
         if (p.in_port == LocalPort) begin
            timer_armed = 1'b1;
            timer_count = '0;
            timer_entry = free_slot;
         end
         if (p.service == SVC_ALL) begin
            mask = mesh_except(p.in_port);
            if (p.src_addr != own_addr) mask[LocalPort] = 1'b1;
         end else if (p.tgt_addr != own_addr) begin
            mask = mesh_except(p.in_port);
         end else begin
            mask = 5'b10000;
         end
         return entry_route(ST_STORED, mask, free_slot, p.service);
      end
      if (hit >= 0 && p.service == SVC_CLEAR) begin
         r = entry_route(ST_CLEARED, mesh_except(cam_origin[hit]), hit, SVC_CLEAR);
         cam_valid[hit] = 1'b0;
         if (timer_armed && timer_entry == hit) timer_armed = 1'b0;
         return r;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (send_wait > 0) begin
         send_wait <= send_wait - 1;
         req_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
         packet_word p;
         p = pending_words.pop_front();
         req_valid <= 1'b1;
         {req_cmd, req_in_port, req_src_addr, req_tgt_addr, req_msg_id, req_service,
          req_payload} <= p;
         send_wait <= calm ? 0 : int'($urandom_range(0, 18));
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_routes.push_back(route_packet({req_cmd, req_in_port, req_src_addr,
            req_tgt_addr, req_msg_id, req_service, req_payload}));
         sent++;
      end
   end

   // monitor
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_wait > 0) begin
         recv_wait <= recv_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         route_word got, want;
         got = {rsp_status, rsp_fwd_mask, rsp_out_source, rsp_out_target, rsp_out_id,
                rsp_out_service, rsp_out_payload};
         received++;
         recv_wait <= calm ? 0 : int'($urandom_range(0, 18));
         if (expected_routes.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
         end else begin
            want = expected_routes.pop_front();
            if (got.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.fwd_mask !== want.fwd_mask)
               $display("%0t: mask exp %b got %b", $time, want.fwd_mask, got.fwd_mask);
            if (got.out_source !== want.out_source)
               $display("%0t: source exp %h got %h", $time, want.out_source, got.out_source);
            if (got.out_target !== want.out_target)
               $display("%0t: target exp %h got %h", $time, want.out_target, got.out_target);
            if (got.out_id !== want.out_id)
               $display("%0t: id exp %h got %h", $time, want.out_id, got.out_id);
            if (got.out_service !== want.out_service)
               $display("%0t: service exp %0d got %0d", $time, want.out_service,
                        got.out_service);
            if (got.out_payload !== want.out_payload)
               $display("%0t: payload exp %h got %h", $time, want.out_payload,
                        got.out_payload);
            if (got !== want) errors++;
         end
      end
   end

   function automatic packet_word make_packet(input logic [2:0] port, input logic [15:0] src,
                                              input logic [15:0] tgt, input logic [5:0] id,
                                              input logic [1:0] svc);
      packet_word p;
      p.cmd = CMD_PACKET;
      p.in_port = port;
      p.src_addr = src;
      p.tgt_addr = tgt;
      p.msg_id = id;
      p.service = svc;
      p.payload = $urandom();
      return p;
   endfunction

   function automatic packet_word make_tick();
      packet_word p;
      p = '0;
      p.cmd = CMD_TICK;
      p.in_port = 3'($urandom_range(0, 7));
      p.src_addr = 16'($urandom());
      p.tgt_addr = 16'($urandom());
      p.msg_id = 6'($urandom());
      p.service = 2'($urandom());
      p.payload = $urandom();
      return p;
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || expected_routes.size() > 0 || req_valid)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_ROUTER_ADDRESS) own_addr = value;
      else interval = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [15:0] addrs [6];
      logic [15:0] intervals [6];
      own_addr = '0;
      interval = ClearIntervalReset;
      timer_armed = 1'b0;
      timer_count = '0;
      timer_entry = 0;
      for (int i = 0; i < Entries; i++) begin
         cam_valid[i] = 1'b0;
         cam_src[i] = '0;
         cam_id[i] = '0;
         cam_origin[i] = '0;
         cam_tgt[i] = '0;
         cam_payload[i] = '0;
      end
      addrs = '{16'h0000, 16'hFFFF, 16'h0102, 16'h0000, 16'h2233, 16'h0001};
      intervals = '{16'd1, 16'd65535, 16'd3, 16'd7, 16'd2, 16'd12};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset-value defaults, then directed cases
      pending_words.push_back(make_tick());
      pending_words.push_back(make_packet(3'd5, 16'h1, 16'h2, 6'd1, SVC_ALL));
      pending_words.push_back(make_packet(3'd7, 16'hFFFF, 16'hFFFF, 6'd63, SVC_ALL));
      pending_words.push_back(make_packet(3'd0, 16'h0000, 16'h0000, 6'd0, SVC_ALL));
      pending_words.push_back(make_packet(3'd1, 16'h0000, 16'h0000, 6'd0, SVC_ALL));
      pending_words.push_back(make_packet(3'd2, 16'hFFFF, 16'h0000, 6'd63, SVC_TARGET));
      pending_words.push_back(make_packet(3'd3, 16'h1234, 16'hFFFF, 6'd5, SVC_TARGET));
      pending_words.push_back(make_packet(3'd4, 16'h0000, 16'h5555, 6'd9, SVC_ALL));
      pending_words.push_back(make_packet(3'd0, 16'h4444, 16'h0, 6'd2, SVC_INVALID));
      pending_words.push_back(make_packet(3'd1, 16'h7777, 16'h0, 6'd2, SVC_CLEAR));
      for (int i = 0; i < 5; i++)
         pending_words.push_back(make_packet(3'(i), 16'hAA00 + 16'(i), 16'h0, 6'(i),
                                             SVC_ALL));
      pending_words.push_back(make_packet(3'd2, 16'hBEEF, 16'h0, 6'd3, SVC_TARGET));
      pending_words.push_back(make_packet(3'd0, 16'h0000, 16'h0, 6'd9, SVC_CLEAR));
      pending_words.push_back(make_packet(3'd4, 16'h0F0F, 16'h0, 6'd44, SVC_ALL));
      pending_words.push_back(make_packet(3'd3, 16'h0F0F, 16'h0, 6'd44, SVC_CLEAR));
      pending_words.push_back(make_packet(3'd1, 16'hFFFF, 16'h0, 6'd63, SVC_CLEAR));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_ROUTER_ADDRESS, addrs[ph]);
         write_reg(CSR_CLEAR_INTERVAL, intervals[ph]);
         calm = (ph == 3);
         for (int n = 0; n < 290; n++) begin
            int kind;
            logic [15:0] src;
            logic [5:0] id;
            kind = int'($urandom_range(0, 99));
            src = ($urandom_range(0, 3) == 0) ? own_addr : 16'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0) src = 16'($urandom());
            id = ($urandom_range(0, 4) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 3));
            if (kind < 25) begin
               pending_words.push_back(make_tick());
            end else if (kind < 60) begin
               pending_words.push_back(make_packet(3'($urandom_range(0, 4)), src,
                  ($urandom_range(0, 2) == 0) ? own_addr : 16'($urandom()), id,
                  2'($urandom_range(0, 1))));
            end else if (kind < 88) begin
               pending_words.push_back(make_packet(3'($urandom_range(0, 4)), src,
                  16'($urandom()), id, SVC_CLEAR));
            end else if (kind < 95) begin
               pending_words.push_back(make_packet(3'($urandom_range(0, 4)), src,
                  16'($urandom()), id, SVC_INVALID));
            end else begin
               pending_words.push_back(make_packet(3'($urandom_range(5, 7)),
                  16'($urandom()), 16'($urandom()), 6'($urandom()), 2'($urandom())));
            end
         end
         drain();
      end

      if (errors == 0 && expected_routes.size() == 0 && received == sent) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/brc_pkg.sv
sv/brc_front.sv
sv/brc_back.sv
sv/broadcast_router_cam.sv
bench/tb.sv
